// ===== design/integer_to_radix_text_defines.svh =====
// Assertion macros used by the checker file.
`ifndef INTEGER_TO_RADIX_TEXT_DEFINES_SVH
`define INTEGER_TO_RADIX_TEXT_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define ITRT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masks the check.
`define ITRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/itrt_pkg.sv =====
package itrt_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int DIGIT_W        = 6;
	localparam int CHAR_W         = 7;
	localparam int BASE_W         = 6;

	localparam logic [BASE_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [BASE_W-1:0] RADIX_MAX = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
	localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} itrt_state_t;

	// divider status towards the sequencer
	typedef struct packed {
		logic done;
		logic quo_zero;
	} div_stat_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] r;
		if (d < DEC_DIGITS)
			r = CHAR_ZERO + CHAR_W'(d);
		else
			r = CHAR_A + CHAR_W'(d - DEC_DIGITS);
		return r;
	endfunction

endpackage

// ===== design/integer_to_radix_text.sv =====
// Channel   | Signals                                   | Handshake
// ----------+-------------------------------------------+----------------------------
// request   | value, base, mode                         | start && !busy
// result    | digit_char, negative, last, empty_res     | strobe, one cycle, no stall
//
// Each digit comes from the bit-serial divider (one quotient bit per cycle);
// all digits of a number are converted first, then the digit buffer is read
// back and the results are presented.
// An invalid radix gives its single empty result on the cycle after the request.
// busy stays high until the last result is on the ports; results cannot be held.
// Reset returns the sequencer to idle; digit buffer contents are left as they are.
module integer_to_radix_text import itrt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [63:0]       value,
	input  logic [BASE_W-1:0] base,
	input  logic              mode,
	output logic              strobe,
	output logic [CHAR_W-1:0] digit_char,
	output logic              negative,
	output logic              last,
	output logic              empty_res
);

	localparam int IDX_W = $clog2(VALUE_BITS);

	itrt_state_t           state_q, state_d;
	logic [IDX_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic [BASE_W-1:0]     base_q;
	logic                  neg_q;
	logic                  rd_vld_s1, rd_last_s1;
	logic                  strobe_q, last_q, empty_q, negative_q;
	logic [CHAR_W-1:0]     char_q;

	logic                  accept, base_ok, is_neg;
	logic [VALUE_BITS-1:0] raw, mag, div_dividend, div_quo;
	logic [DIGIT_W-1:0]    div_rem, rd_data;
	div_stat_t             div_stat;
	logic                  div_load, mem_we, finish, emit_rd;

	assign accept  = start && !busy;
	assign base_ok = (base >= RADIX_MIN) && (base <= RADIX_MAX);
	assign raw     = value[VALUE_BITS-1:0];
	assign is_neg  = mode && raw[VALUE_BITS-1];
	// two's complement magnitude; the most negative value maps onto itself
	assign mag     = is_neg ? (~raw + VALUE_BITS'(1)) : raw;
	assign finish  = div_stat.quo_zero || (cnt_q == IDX_W'(VALUE_BITS - 1));

	assign div_dividend = (state_q == ST_IDLE) ? mag : div_quo;

	always_comb begin
		state_d  = state_q;
		div_load = 1'b0;
		mem_we   = 1'b0;
		emit_rd  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && base_ok) begin
					div_load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					mem_we = 1'b1;
					if (finish)
						state_d = ST_EMIT;
					else
						div_load = 1'b1;
				end
			end
			ST_EMIT: begin
				emit_rd = 1'b1;
				if (rd_idx_q == '0)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			rd_idx_q   <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_vld_s1  <= emit_rd;
			rd_last_s1 <= emit_rd && (rd_idx_q == '0);
			if (state_q == ST_IDLE && accept)
				cnt_q <= '0;
			else if (mem_we && !finish)
				cnt_q <= cnt_q + IDX_W'(1);
			if (mem_we && finish)
				rd_idx_q <= cnt_q;
			else if (emit_rd && rd_idx_q != '0)
				rd_idx_q <= rd_idx_q - IDX_W'(1);
			strobe_q <= rd_vld_s1 || (accept && !base_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base;
			neg_q  <= is_neg;
		end
		if (accept && !base_ok) begin
			char_q     <= '0;
			negative_q <= 1'b0;
			last_q     <= 1'b1;
			empty_q    <= 1'b1;
		end else begin
			char_q     <= digit_to_ascii(rd_data);
			negative_q <= neg_q;
			last_q     <= rd_last_s1;
			empty_q    <= 1'b0;
		end
	end

	itrt_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (div_dividend),
		.radix    (base_q),
		.stat     (div_stat),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	itrt_digit_store #(
		.DEPTH(VALUE_BITS)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(cnt_q),
		.wdata(div_rem),
		.raddr(rd_idx_q),
		.rdata(rd_data)
	);

	assign busy       = (state_q != ST_IDLE) || rd_vld_s1;
	assign strobe     = strobe_q;
	assign digit_char = char_q;
	assign negative   = negative_q;
	assign last       = last_q;
	assign empty_res  = empty_q;

endmodule

// ===== design/itrt_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module itrt_divider import itrt_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [BASE_W-1:0]     radix,
	output div_stat_t             stat,
	output logic [VALUE_BITS-1:0] quotient,
	output logic [DIGIT_W-1:0]    remainder
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [DIGIT_W:0]      trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign fits  = trial >= {1'b0, radix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == CNT_W'(1));
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(VALUE_BITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (run_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], fits};
			rem_q <= fits ? DIGIT_W'(trial - {1'b0, radix}) : DIGIT_W'(trial);
		end
	end

	assign stat.done     = done_q;
	assign stat.quo_zero = (quo_q == '0);
	assign quotient      = quo_q;
	assign remainder     = rem_q;

endmodule

// ===== design/itrt_digit_store.sv =====
// Digit buffer, written least significant first, read back in reverse.
module itrt_digit_store import itrt_pkg::*; #(
	parameter int DEPTH = VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DIGIT_W-1:0]       wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DIGIT_W-1:0]       rdata
);

	logic [DIGIT_W-1:0] mem [DEPTH];
	logic [DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/itrt_checker.sv =====
`include "integer_to_radix_text_defines.svh"

module itrt_checker import itrt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [BASE_W-1:0] base,
	input logic              strobe,
	input logic [CHAR_W-1:0] digit_char,
	input logic              negative,
	input logic              last,
	input logic              empty_res
);

	logic bad_req, good_req;

	assign bad_req  = start && !busy && ((base < RADIX_MIN) || (base > RADIX_MAX));
	assign good_req = start && !busy && (base >= RADIX_MIN) && (base <= RADIX_MAX);

	`ITRT_ASSERT_NEXT(a_bad_radix_empty, bad_req, strobe && empty_res, "invalid radix gave no empty result")
	`ITRT_ASSERT_NEXT(a_good_radix_busy, good_req, busy && !strobe, "valid request did not hold busy")
	`ITRT_ASSERT_NOW(a_empty_shape, strobe && empty_res, last && !negative && (digit_char == '0), "malformed empty result")
	`ITRT_ASSERT_NOW(a_char_range, strobe && !empty_res, ((digit_char >= 7'h30) && (digit_char <= 7'h39)) || ((digit_char >= 7'h61) && (digit_char <= 7'h7a)), "digit outside radix alphabet")
	`ITRT_ASSERT_NOW(a_more_pending, strobe && !empty_res && !last, busy, "text ended without last")

endmodule

bind integer_to_radix_text itrt_checker u_chk (.*);
